[hdl/srld_pkg.sv]
// Shared types and constants for the sprite run-length decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package srld_pkg;

   localparam int SPRITE_SIDE  = 32;
   localparam int FRAME_PIXELS = SPRITE_SIDE * SPRITE_SIDE;
   localparam int START_W      = $clog2(FRAME_PIXELS);
   localparam int LEN_W        = $clog2(FRAME_PIXELS + 1);
   localparam int POS_W        = LEN_W;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [7:0] KEY_COLOR_RESET = 8'h11;
   localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;
   localparam logic [7:0] CHANNEL_ZERO    = 8'h00;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_HAVE_ALPHA  = 2'd0;
   localparam csr_index_type CSR_OUTPUT_MODE = 2'd1;
   localparam csr_index_type CSR_KEY_COLOR   = 2'd2;

   typedef enum logic [2:0] {
      PH_TLO,
      PH_THI,
      PH_CLO,
      PH_CHI,
      PH_PIX
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_sprite;
   } req_type;

   typedef struct packed {
      logic [START_W-1:0] start_pixel;
      logic [LEN_W-1:0]   run_length;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic               is_transparent;
      logic               last;
   } rsp_type;

   // Up to two results caused by one input byte.
   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } pair_type;

endpackage

`default_nettype wire

[hdl/srld_front.sv]
// Front end: configuration registers and the byte parser that turns each
// accepted byte into up to two result records. Uses srld_pkg.
`default_nettype none

module srld_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   in_ready,
   input  wire srld_pkg::req_type      req_data,
   input  wire logic                   csr_valid,
   input  wire srld_pkg::csr_index_type csr_index,
   input  wire logic [7:0]             csr_data,
   output logic                        push,
   output srld_pkg::pair_type          push_data
);
   import srld_pkg::*;

   logic       have_alpha_ff, mode_ff;
   logic [7:0] key_ff;

   phase_type        phase_ff, phase_in;
   logic [7:0]       low_ff, low_in;
   logic [15:0]      left_ff, left_in;
   logic [1:0]       idx_ff, idx_in;
   logic [7:0]       red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [POS_W-1:0] pos_ff, pos_in, pos_mid;

   logic [15:0]      count16;
   logic [LEN_W-1:0] room, tlen;
   logic [7:0]       tcolor;
   logic             fire, eos, done;
   logic [7:0]       alpha;
   pair_type         pair;

   function automatic rsp_type transp(input logic [START_W-1:0] start,
                                      input logic [LEN_W-1:0] len,
                                      input logic [7:0] c,
                                      input logic is_last);
      rsp_type r;
      r.start_pixel    = start;
      r.run_length     = len;
      r.red            = c;
      r.green          = c;
      r.blue           = c;
      r.alpha          = CHANNEL_ZERO;
      r.is_transparent = 1'b1;
      r.last           = is_last;
      return r;
   endfunction

   assign fire    = req_valid && in_ready;
   assign eos     = req_data.end_of_sprite;
   assign count16 = {req_data.data_byte, low_ff};
   assign room    = LEN_W'(FRAME_PIXELS) - pos_ff;
   assign tlen    = (count16 < 16'(room)) ? count16[LEN_W-1:0] : room;
   assign tcolor  = mode_ff ? CHANNEL_ZERO : key_ff;

   always_comb begin
      phase_in = phase_ff;
      low_in   = low_ff;
      left_in  = left_ff;
      idx_in   = idx_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      pos_mid  = pos_ff;
      pair     = '0;
      done     = 1'b0;
      alpha    = ALPHA_OPAQUE;
      unique case (phase_ff)
         PH_THI: begin
            if (tlen != '0) begin
               pair.first_valid = 1'b1;
               pair.first       = transp(pos_ff[START_W-1:0], tlen, tcolor, 1'b0);
               pos_mid          = pos_ff + tlen;
            end
            phase_in = PH_CLO;
         end
         PH_CLO: begin
            low_in   = req_data.data_byte;
            phase_in = PH_CHI;
         end
         PH_CHI: begin
            left_in  = count16;
            idx_in   = 2'd0;
            phase_in = (count16 != 16'd0) ? PH_PIX : PH_TLO;
         end
         PH_PIX: begin
            unique case (idx_ff)
               2'd0: red_in = req_data.data_byte;
               2'd1: green_in = req_data.data_byte;
               2'd2: begin
                  blue_in = req_data.data_byte;
                  done    = !have_alpha_ff;
               end
               default: begin
                  alpha = req_data.data_byte;
                  done  = 1'b1;
               end
            endcase
            if (done) begin
               idx_in  = 2'd0;
               left_in = left_ff - 16'd1;
               if (left_in == 16'd0) begin
                  phase_in = PH_TLO;
               end
            end else begin
               idx_in = idx_ff + 2'd1;
            end
            // A pixel cut off right before its alpha byte still shows in ARGB mode.
            if ((done || (eos && idx_ff == 2'd2 && mode_ff))
                && pos_ff < POS_W'(FRAME_PIXELS)) begin
               pair.first_valid          = 1'b1;
               pair.first.start_pixel    = pos_ff[START_W-1:0];
               pair.first.run_length     = LEN_W'(1);
               pair.first.red            = red_in;
               pair.first.green          = green_in;
               pair.first.blue           = blue_in;
               pair.first.alpha          = mode_ff ? alpha : ALPHA_OPAQUE;
               pair.first.is_transparent = 1'b0;
               pair.first.last           = 1'b0;
               pos_mid                   = pos_ff + POS_W'(1);
            end
         end
         default: begin
            low_in   = req_data.data_byte;
            phase_in = PH_THI;
         end
      endcase
      pos_in = pos_mid;
      if (eos) begin
         pair.second_valid = 1'b1;
         if (pos_mid < POS_W'(FRAME_PIXELS)) begin
            pair.second = transp(pos_mid[START_W-1:0],
                                 LEN_W'(FRAME_PIXELS) - pos_mid, tcolor, 1'b1);
         end else begin
            pair.second = transp('0, '0, tcolor, 1'b1);
         end
         phase_in = PH_TLO;
         low_in   = '0;
         left_in  = '0;
         idx_in   = '0;
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
         pos_in   = '0;
      end
   end

   assign push      = fire && (pair.first_valid || pair.second_valid);
   assign push_data = pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_alpha_ff <= 1'b0;
         mode_ff       <= 1'b0;
         key_ff        <= KEY_COLOR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HAVE_ALPHA:  have_alpha_ff <= csr_data[0];
            CSR_OUTPUT_MODE: mode_ff       <= csr_data[0];
            CSR_KEY_COLOR:   key_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TLO;
         low_ff   <= '0;
         left_ff  <= '0;
         idx_ff   <= '0;
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         pos_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         low_ff   <= low_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

[hdl/srld_queue.sv]
// Short FIFO of result pairs between the parser and the output stage.
// Uses srld_pkg for the entry type and depth.
`default_nettype none

module srld_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire srld_pkg::pair_type push_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output srld_pkg::pair_type      head
);
   import srld_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   pair_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [PTR_W:0]     count_ff;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + PTR_W'(1);
         end
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

endmodule

`default_nettype wire

[hdl/srld_back.sv]
// Back end: unpacks queued result pairs and drives the registered output beat.
// Uses srld_pkg for the pair and result types.
`default_nettype none

module srld_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_not_empty,
   input  wire srld_pkg::pair_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output srld_pkg::rsp_type       rsp_data
);
   import srld_pkg::*;

   rsp_type out_ff, hold_ff;
   logic    out_valid_ff, hold_valid_ff;
   logic    load;

   assign load      = !out_valid_ff || rsp_ready;
   assign q_pop     = load && !hold_valid_ff && q_not_empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // The second result of a pair waits in the hold register while the first is on the output.
   always_ff @(posedge clock) begin
      if (load) begin
         if (hold_valid_ff) begin
            out_ff <= hold_ff;
         end else if (q_not_empty) begin
            out_ff  <= q_head.first_valid ? q_head.first : q_head.second;
            hold_ff <= q_head.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (load) begin
         if (hold_valid_ff) begin
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= 1'b0;
         end else if (q_not_empty) begin
            out_valid_ff  <= 1'b1;
            hold_valid_ff <= q_head.first_valid && q_head.second_valid;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

[hdl/sprite_run_length_decoder.sv]
// Top level of the sprite run-length decoder: parser front end, pair queue
// and output stage. Depends on srld_pkg, srld_front, srld_queue, srld_back.
//
// The decoder takes one compressed sprite byte per clock until the queue is
// full and emits pixel runs for a 32x32 frame in raster order. Every byte is
// parsed in the cycle it is accepted and yields zero, one or two runs; these
// enter a four-entry queue, and the output register sends one run per cycle
// while rsp_ready is high; of a byte that yields two runs (a run plus the
// end-of-sprite fill), the second waits in the hold register. A run reaches
// the output through a queue entry and the output register. Nothing is
// cleared after reset, so bytes are accepted from the first cycle.
// Configuration writes are always accepted and take effect at once; they
// should be issued only between sprites with the block drained.
`default_nettype none

module sprite_run_length_decoder (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire srld_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output srld_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire srld_pkg::csr_index_type csr_index,
   input  wire logic [7:0]              csr_data
);
   import srld_pkg::*;

   logic     push, pop, full, not_empty;
   pair_type push_data, head;

   assign req_ready = !full;
   assign csr_ready = 1'b1;

   srld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .in_ready  (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .push_data (push_data)
   );

   srld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   srld_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/srld_checker.sv]
// Port-level checks for the sprite run-length decoder, bound to the top level.
// Depends on srld_pkg and sprite_run_length_decoder.
`default_nettype none

module srld_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire srld_pkg::rsp_type rsp_data
);
   import srld_pkg::*;

   logic [LEN_W:0] run_end;
   assign run_end = (LEN_W+1)'(rsp_data.start_pixel) + (LEN_W+1)'(rsp_data.run_length);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_length == '0 |->
         rsp_data.last && rsp_data.is_transparent && rsp_data.start_pixel == '0)
      else $error("empty run that is not an end marker");

   a_colored_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_transparent |->
         rsp_data.run_length == LEN_W'(1) && !rsp_data.last)
      else $error("colored run not a single pixel");

   a_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> run_end <= (LEN_W+1)'(FRAME_PIXELS))
      else $error("run extends past the frame");

endmodule

bind sprite_run_length_decoder srld_checker u_srld_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
